### sv/hed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, entity pattern table and controller/datapath interface.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int BYTE_W    = 8;
  localparam int PEND_MAX  = 8;   // longest entity text, "&eacute;"
  localparam int PEND_W    = 3;   // buffered prefix holds at most 7 bytes
  localparam int NUM_MAX   = 5;   // characters collected after "&#"
  localparam int DCNT_W    = 3;
  localparam int TOT_W     = 4;   // results per transfer, at most 8
  localparam int NUM_PAT   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MIN  = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;

  localparam logic [7:0] EACUTE_RST = 8'hE9;
  localparam logic [7:0] IUML_RST   = 8'hEF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EACUTE = 1'b0,
    REG_IUML   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_EACUTE,
    KIND_IUML,
    KIND_NUMERIC
  } pat_kind_t;

  typedef enum logic [1:0] {
    PH_WS,
    PH_SIGN,
    PH_DIG,
    PH_BAD
  } num_phase_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } hed_state_t;

  // texts left aligned, first character in the top byte
  localparam logic [63:0] PAT_TEXT [NUM_PAT] = '{
    {"&amp;", 24'h0},
    {"&quot;", 16'h0},
    {"&lt;", 32'h0},
    {"&gt;", 32'h0},
    "&eacute;",
    {"&iuml;", 16'h0},
    {"&#", 48'h0}
  };

  localparam logic [3:0] PAT_LEN [NUM_PAT] = '{
    4'd5, 4'd6, 4'd4, 4'd4, 4'd8, 4'd6, 4'd2
  };

  localparam pat_kind_t PAT_KIND [NUM_PAT] = '{
    KIND_FIXED, KIND_FIXED, KIND_FIXED, KIND_FIXED,
    KIND_EACUTE, KIND_IUML, KIND_NUMERIC
  };

  localparam logic [7:0] PAT_VAL [NUM_PAT] = '{
    8'h26, 8'h22, 8'h3C, 8'h3E, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] pat_char(input logic [63:0] text,
                                          input logic [PEND_W-1:0] pos);
    logic [5:0] base;
    base = {3'(3'd7 - pos), 3'b000};
    return text[base +: 8];
  endfunction

  typedef struct packed {
    logic accept;  // load a new input transfer
    logic emit;    // load next result into the output register
  } hed_cmd_t;

  typedef struct packed {
    logic no_results;  // current transfer produces nothing
    logic emit_final;  // result being selected is the last of the transfer
    logic out_free;    // output register can take a result
  } hed_status_t;

endpackage

`default_nettype wire

### sv/hed_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_ctrl
// Sequencer: takes one input transfer, then steps the datapath through its
// results one per cycle as the output register frees up.
// ----------------------------------------------------------------------------
module hed_ctrl
  import hed_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  hed_status_t sts,
  output hed_cmd_t    cmd
);

  hed_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        s_tready   = !rst;
        cmd.accept = s_tvalid && !rst;
        if (s_tvalid && !rst) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.no_results) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_final) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### sv/hed_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hed_datapath
// Decoder state, entity matching, incremental numeric parse, per-transfer
// result plan and the output register.
// ----------------------------------------------------------------------------
module hed_datapath
  import hed_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  hed_cmd_t             cmd,
  output hed_status_t          sts,
  input  wire [7:0]            s_tdata,    // [7:0] in_byte
  input  wire                  s_tlast,
  output logic [7:0]           m_tdata,    // [7:0] out_byte
  output logic [1:0]           m_tuser,    // [0] byte_valid, [1] run_last
  output logic                 m_tlast,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  input  wire                  cfg_valid,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [7:0]            cfg_data
);

  // configuration
  logic [7:0] eacute_code, iuml_code;

  // decoder state
  logic [7:0]          pbuf [PEND_MAX];
  logic [PEND_W-1:0]   pcount, pcount_next;
  logic [NUM_PAT-1:0]  pmask, pmask_next;
  logic                num_mode, num_mode_next;
  logic [DCNT_W-1:0]   dcount, dcount_next;
  num_phase_t          phase, phase_next;
  logic                neg, neg_next;
  logic [7:0]          acc, acc_next;
  logic                skip, skip_next;

  // plan of the transfer being emitted
  logic [PEND_W-1:0]   k1;
  logic                one_vld;
  logic [7:0]          one_val;
  logic                last_q;
  logic                marker;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    pos;

  // combinational step results
  logic [PEND_W-1:0]   k1_c, k2_c;
  logic                one_vld_c;
  logic [7:0]          one_val_c;
  logic                wr_en;
  logic [PEND_W-1:0]   wr_addr;
  logic [TOT_W-1:0]    total_c;

  logic [7:0]          c;
  logic [3:0]          n_len;
  logic [NUM_PAT-1:0]  hit;
  logic                any_full, any_part;
  logic [2:0]          full_idx;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_SP) || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  assign c = s_tdata;

  // entity prefix match against the pattern table
  always_comb begin
    n_len    = 4'({1'b0, pcount}) + 4'd1;
    hit      = '0;
    any_full = 1'b0;
    any_part = 1'b0;
    full_idx = '0;
    for (int i = 0; i < NUM_PAT; i++) begin
      hit[i] = pmask[i] && (n_len <= PAT_LEN[i]) && (pat_char(PAT_TEXT[i], pcount) == c);
      if (hit[i] && n_len == PAT_LEN[i]) begin
        any_full = 1'b1;
        full_idx = 3'(i);
      end
      if (hit[i] && n_len != PAT_LEN[i]) begin
        any_part = 1'b1;
      end
    end
  end

  // one input byte through the decoder
  always_comb begin
    pcount_next   = pcount;
    pmask_next    = pmask;
    num_mode_next = num_mode;
    dcount_next   = dcount;
    phase_next    = phase;
    neg_next      = neg;
    acc_next      = acc;
    skip_next     = skip;
    k1_c          = '0;
    k2_c          = '0;
    one_vld_c     = 1'b0;
    one_val_c     = c;
    wr_en         = 1'b0;
    wr_addr       = '0;

    if (skip) begin
      skip_next = 1'b0;
    end else if (num_mode) begin
      if (c == CH_SEMI) begin
        one_vld_c     = (phase == PH_DIG);
        one_val_c     = neg ? 8'(-acc) : acc;
        num_mode_next = 1'b0;
        dcount_next   = '0;
      end else begin
        unique case (phase)
          PH_WS: begin
            if (is_ws(c)) begin
              phase_next = PH_WS;
            end else if (c == CH_PLUS || c == CH_MIN) begin
              phase_next = PH_SIGN;
              neg_next   = (c == CH_MIN);
            end else if (is_digit(c)) begin
              phase_next = PH_DIG;
              acc_next   = 8'(c - CH_ZERO);
            end else begin
              phase_next = PH_BAD;
            end
          end
          PH_SIGN, PH_DIG: begin
            if (is_digit(c)) begin
              phase_next = PH_DIG;
              acc_next   = 8'({acc[4:0], 3'b000}) + 8'({acc[6:0], 1'b0}) + 8'(c - CH_ZERO);
            end else begin
              phase_next = PH_BAD;
            end
          end
          PH_BAD: phase_next = PH_BAD;
          default: phase_next = PH_BAD;
        endcase
        dcount_next = dcount + DCNT_W'(1);
        if (dcount_next == DCNT_W'(NUM_MAX)) begin
          one_vld_c     = (phase_next == PH_DIG);
          one_val_c     = neg_next ? 8'(-acc_next) : acc_next;
          num_mode_next = 1'b0;
          dcount_next   = '0;
          skip_next     = 1'b1;
        end
      end
    end else if (pcount != '0 && (any_full || any_part)) begin
      if (any_full) begin
        pcount_next = '0;
        unique case (PAT_KIND[full_idx])
          KIND_FIXED: begin
            one_vld_c = 1'b1;
            one_val_c = PAT_VAL[full_idx];
          end
          KIND_EACUTE: begin
            one_vld_c = 1'b1;
            one_val_c = eacute_code;
          end
          KIND_IUML: begin
            one_vld_c = 1'b1;
            one_val_c = iuml_code;
          end
          KIND_NUMERIC: begin
            num_mode_next = 1'b1;
            dcount_next   = '0;
            phase_next    = PH_WS;
            neg_next      = 1'b0;
            acc_next      = '0;
          end
          default: one_vld_c = 1'b0;
        endcase
      end else begin
        pcount_next = n_len[PEND_W-1:0];
        pmask_next  = hit;
        wr_en       = 1'b1;
        wr_addr     = pcount;
      end
    end else begin
      // broken prefix goes out literally, then this byte starts afresh
      k1_c        = pcount;
      pcount_next = '0;
      if (c == CH_AMP) begin
        pcount_next = PEND_W'(1);
        pmask_next  = '1;
        wr_en       = 1'b1;
        wr_addr     = '0;
      end else begin
        one_vld_c = 1'b1;
      end
    end

    if (s_tlast) begin
      if (num_mode_next) begin
        one_vld_c = (phase_next == PH_DIG);
        one_val_c = neg_next ? 8'(-acc_next) : acc_next;
      end
      k2_c          = pcount_next;
      pcount_next   = '0;
      num_mode_next = 1'b0;
      dcount_next   = '0;
      skip_next     = 1'b0;
    end

    total_c = TOT_W'(k1_c) + TOT_W'(one_vld_c) + TOT_W'(k2_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eacute_code <= EACUTE_RST;
      iuml_code   <= IUML_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EACUTE: eacute_code <= cfg_data;
        REG_IUML:   iuml_code   <= cfg_data;
        default:    eacute_code <= eacute_code;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount   <= '0;
      num_mode <= 1'b0;
      dcount   <= '0;
      skip     <= 1'b0;
      total    <= '0;
      pos      <= '0;
    end else if (cmd.accept) begin
      pcount   <= pcount_next;
      num_mode <= num_mode_next;
      dcount   <= dcount_next;
      skip     <= skip_next;
      total    <= (s_tlast && total_c == '0) ? TOT_W'(1) : total_c;
      pos      <= '0;
    end else if (cmd.emit) begin
      pos <= pos + TOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pmask   <= pmask_next;
      phase   <= phase_next;
      neg     <= neg_next;
      acc     <= acc_next;
      k1      <= k1_c;
      one_vld <= one_vld_c;
      one_val <= one_val_c;
      last_q  <= s_tlast;
      marker  <= s_tlast && (total_c == '0);
      if (wr_en) begin
        pbuf[wr_addr] <= c;
      end
    end
  end

  // result selection: end marker, or old prefix bytes, single byte, then flushed prefix
  logic [TOT_W-1:0]  rd_pos;
  logic [7:0]        sel_byte;
  logic              sel_vld;

  always_comb begin
    rd_pos   = pos - TOT_W'(k1) - TOT_W'(one_vld);
    sel_vld  = 1'b1;
    if (marker) begin
      sel_byte = '0;
      sel_vld  = 1'b0;
    end else if (pos < TOT_W'(k1)) begin
      sel_byte = pbuf[pos[PEND_W-1:0]];
    end else if (one_vld && pos == TOT_W'(k1)) begin
      sel_byte = one_val;
    end else begin
      sel_byte = pbuf[rd_pos[PEND_W-1:0]];
    end
  end

  assign sts.no_results = (total == '0);
  assign sts.emit_final = (pos == total - TOT_W'(1));
  assign sts.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= sel_byte;
      m_tuser <= {sts.emit_final, sel_vld};
      m_tlast <= sts.emit_final && last_q;
    end
  end

  property p_emit_in_range;
    @(posedge clk) disable iff (rst) cmd.emit |-> (pos < total);
  endproperty
  a_emit_in_range: assert property (p_emit_in_range)
    else $error("result emitted beyond planned count");

  property p_num_no_prefix;
    @(posedge clk) disable iff (rst) num_mode |-> (pcount == '0);
  endproperty
  a_num_no_prefix: assert property (p_num_no_prefix)
    else $error("numeric mode with buffered prefix");

  property p_last_clears;
    @(posedge clk) disable iff (rst)
      (cmd.accept && s_tlast) |=> (pcount == '0 && !num_mode && !skip);
  endproperty
  a_last_clears: assert property (p_last_clears)
    else $error("state not cleared after end of string");

  property p_marker_is_end;
    @(posedge clk) disable iff (rst)
      (cmd.emit && !sel_vld) |=> (m_tlast && m_tuser[1]);
  endproperty
  a_marker_is_end: assert property (p_marker_is_end)
    else $error("end marker not flagged as final");

endmodule

`default_nettype wire

### sv/html_entity_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// html_entity_decoder
// Streaming HTML entity decoder: raw text bytes in, decoded bytes out.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   s_*      | in        | s_tvalid / s_tready | tdata in_byte, tlast in_last
//   m_*      | out       | m_tvalid / m_tready | tdata out_byte, tlast string_end,
//            |           |                     | tuser {run_last, byte_valid}
//   cfg_*    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A byte is taken in the idle state, then its results are loaded one per cycle
// while the output register is free (a byte that yields nothing still passes
// through the run state); up to eight results per byte when a broken prefix is
// replayed or flushed at the end of the string. Output register decouples
// m_tready; the next byte is taken while the final result of the previous one
// waits. Synchronous reset, ready low while it is held; no clearing pass.
// ----------------------------------------------------------------------------
module html_entity_decoder
  import hed_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire [7:0]            s_tdata,    // [7:0] in_byte
  input  wire                  s_tlast,    // in_last
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [7:0]           m_tdata,    // [7:0] out_byte
  output logic [1:0]           m_tuser,    // [0] byte_valid, [1] run_last
  output logic                 m_tlast,    // string_end
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [7:0]            cfg_data
);

  hed_cmd_t    cmd;
  hed_status_t sts;

  assign cfg_ready = !rst;

  hed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hed_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams text strings through html_entity_decoder and checks every decoded
// transfer against a byte-level decoder kept in the scoreboard. Starts with
// hand-picked strings, then runs random entity-heavy text under several code
// register settings, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module testbench;
  import hed_pkg::*;

  localparam int PHASE_ITEMS  = 55;
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_LIMIT   = 1000;
  localparam int MAX_PER_BYTE = 10;

  typedef logic [7:0] text_q_t[$];

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       str_end;
    logic       run_end;
  } decoded_t;

  class decoded_text_board;
    logic [7:0]  eacute_val;
    logic [7:0]  iuml_val;
    logic [7:0]  held [PEND_MAX];
    int unsigned held_n;
    bit          in_number;
    logic [7:0]  num_text [NUM_MAX];
    int unsigned num_n;
    bit          drop_next;
    string       ent_text [NUM_PAT];
    pat_kind_t   ent_kind [NUM_PAT];
    logic [7:0]  ent_val [NUM_PAT];
    decoded_t    step_q[$];
    decoded_t    decoded_q[$];
    int          errors;

    function new();
      ent_text = '{"&amp;", "&quot;", "&lt;", "&gt;", "&eacute;", "&iuml;", "&#"};
      ent_kind = '{KIND_FIXED, KIND_FIXED, KIND_FIXED, KIND_FIXED,
                   KIND_EACUTE, KIND_IUML, KIND_NUMERIC};
      ent_val  = '{CH_AMP, 8'h22, 8'h3C, 8'h3E, 8'h00, 8'h00, 8'h00};
      eacute_val = EACUTE_RST;
      iuml_val   = IUML_RST;
      held_n     = 0;
      in_number  = 0;
      num_n      = 0;
      drop_next  = 0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [7:0] val);
      case (idx)
        REG_EACUTE: eacute_val = val;
        REG_IUML:   iuml_val = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void put(logic [7:0] b);
      if (step_q.size() < MAX_PER_BYTE) step_q.push_back('{b, 1'b1, 1'b0, 1'b0});
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // strtol-style: blanks, one sign, digits, nothing trailing
    function void number_value();
      int unsigned i;
      bit neg;
      bit any;
      logic [31:0] acc;
      i = 0;
      neg = 0;
      any = 0;
      acc = '0;
      while (i < num_n && is_space(num_text[i])) i++;
      if (i < num_n && (num_text[i] == CH_PLUS || num_text[i] == CH_MIN)) begin
        neg = (num_text[i] == CH_MIN);
        i++;
      end
      while (i < num_n && num_text[i] >= CH_ZERO && num_text[i] <= CH_NINE) begin
        acc = acc * 10 + 32'(num_text[i] - CH_ZERO);
        any = 1;
        i++;
      end
      if (any && i == num_n) begin
        if (neg) acc = -acc;
        put(acc[7:0]);
      end
    endfunction

    function void begin_text(logic [7:0] c);
      if (c == CH_AMP) begin
        held[0] = c;
        held_n = 1;
      end else begin
        put(c);
      end
    endfunction

    function void scan(logic [7:0] c);
      int unsigned n;
      int full;
      bit part;
      bit hit;
      full = -1;
      part = 0;
      if (drop_next) begin
        drop_next = 0;
        return;
      end
      if (in_number) begin
        if (c == CH_SEMI) begin
          number_value();
          in_number = 0;
          num_n = 0;
          return;
        end
        if (num_n < NUM_MAX) begin
          num_text[num_n] = c;
          num_n++;
        end
        // limit reached: evaluate and swallow the following byte
        if (num_n >= NUM_MAX) begin
          number_value();
          in_number = 0;
          num_n = 0;
          drop_next = 1;
        end
        return;
      end
      if (held_n == 0 || held_n >= PEND_MAX) begin
        held_n = 0;
        begin_text(c);
        return;
      end
      held[held_n] = c;
      n = held_n + 1;
      for (int i = 0; i < NUM_PAT; i++) begin
        if (n <= ent_text[i].len()) begin
          hit = 1;
          for (int k = 0; k < n; k++)
            if (held[k] != 8'(ent_text[i][k])) hit = 0;
          if (hit) begin
            if (n == ent_text[i].len()) full = i;
            else part = 1;
          end
        end
      end
      if (full >= 0) begin
        held_n = 0;
        case (ent_kind[full])
          KIND_FIXED:  put(ent_val[full]);
          KIND_EACUTE: put(eacute_val);
          KIND_IUML:   put(iuml_val);
          default: begin
            in_number = 1;
            num_n = 0;
          end
        endcase
        return;
      end
      if (part && n < PEND_MAX) begin
        held_n = n;
        return;
      end
      // dead prefix: replay it literally, rescan the breaking byte
      for (int i = 0; i < held_n; i++) put(held[i]);
      held_n = 0;
      begin_text(c);
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int top;
      step_q.delete();
      scan(b);
      if (last) begin
        if (in_number) number_value();
        for (int i = 0; i < held_n; i++) put(held[i]);
        held_n = 0;
        in_number = 0;
        num_n = 0;
        drop_next = 0;
        if (step_q.size() == 0) step_q.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
        top = step_q.size() - 1;
        step_q[top].str_end = 1'b1;
      end
      if (step_q.size() > 0) begin
        top = step_q.size() - 1;
        step_q[top].run_end = 1'b1;
      end
      foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_byte(logic [7:0] data, logic valid, logic str_end, logic run_end);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected transfer out_byte=%h", data));
        return;
      end
      want = decoded_q.pop_front();
      if (data !== want.data)
        report($sformatf("out_byte %h, want %h", data, want.data));
      if (valid !== want.valid)
        report($sformatf("byte_valid %b, want %b", valid, want.valid));
      if (str_end !== want.str_end)
        report($sformatf("string_end %b, want %b", str_end, want.str_end));
      if (run_end !== want.run_end)
        report($sformatf("run_last %b, want %b", run_end, want.run_end));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_reg_t   cfg_index = REG_EACUTE;
  logic [7:0] cfg_data = 8'h00;

  decoded_text_board sb = new();
  int        burst_left = 0;
  int        idle_cycles = 0;
  int        rx_hold = 0;
  logic [9:0] rx_cycle = '0;

  html_entity_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: free-running, random, sparse, then long random stalls
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 1) == 1);
      2'd2: m_tready <= (rx_cycle[1:0] == 2'd3);
      default: begin
        if (rx_hold == 0) begin
          m_tready <= !m_tready;
          rx_hold <= $urandom_range(1, 10);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_byte(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void add_str(ref text_q_t t, input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(8'(s[i]));
  endfunction

  function automatic text_q_t random_text();
    text_q_t t;
    int k;
    int cut;
    string named [6];
    named = '{"&amp;", "&quot;", "&lt;", "&gt;", "&eacute;", "&iuml;"};
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(0, 255)));
        2, 3, 4: add_str(t, named[$urandom_range(0, 5)]);
        5, 6: begin
          add_str(t, "&#");
          if ($urandom_range(0, 3) == 0) t.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
          if ($urandom_range(0, 2) == 0) t.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MIN);
          repeat ($urandom_range(1, 3)) t.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 4) != 0) t.push_back(CH_SEMI);
        end
        7: begin
          add_str(t, "&#");
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 3))
              0: t.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
              1: t.push_back(8'($urandom_range(0, 255)));
              2: t.push_back($urandom_range(0, 1) ? CH_MIN : CH_CR);
              default: t.push_back(CH_SEMI);
            endcase
          end
        end
        8: begin
          // truncated entity followed by a random byte
          k = $urandom_range(0, 5);
          cut = $urandom_range(1, named[k].len() - 1);
          add_str(t, named[k].substr(0, cut - 1));
          t.push_back(8'($urandom_range(0, 255)));
        end
        default: repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(97, 122)));
      endcase
    end
    return t;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(input text_q_t t);
    for (int i = 0; i < t.size(); i++) send_byte(t[i], i == t.size() - 1);
  endtask

  task automatic send_str(input string s);
    text_q_t t;
    add_str(t, s);
    send_text(t);
  endtask

  // checked at the falling edge, clear of the monitor, then back on the rising edge
  task automatic wait_drained();
    @(negedge clk);
    while (sb.pending() > 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] eacute, input logic [7:0] iuml);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_EACUTE;
    cfg_data  <= eacute;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(REG_EACUTE, eacute);
    cfg_index <= REG_IUML;
    cfg_data  <= iuml;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(REG_IUML, iuml);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    text_q_t t;
    int sent;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_str("&lt;");
    send_str("&#-1;");
    send_str("&#;");        // empty number, ends with only an end marker
    send_str("&#12345x");   // limit hit, x swallowed
    send_str("&qx");        // broken prefix replayed
    send_str("&");          // prefix flushed at end of string
    send_str("&#4");        // number evaluated at end of string
    t = '{8'h00, CH_AMP, 8'h23, 8'h00, CH_SEMI, 8'hFF};
    send_text(t);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_regs(8'h00, 8'hFF);
        1: write_regs(8'hFF, 8'h00);
        default: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 15) == 0) begin
          s_tvalid <= 1'b0;
          wait_drained();
        end
        t = random_text();
        send_text(t);
        sent += t.size();
      end
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
sv/hed_pkg.sv
sv/hed_ctrl.sv
sv/hed_datapath.sv
sv/html_entity_decoder.sv
verif/testbench.sv
